@@ src/ttbh_pkg.sv @@
// Shared constants, types and helpers for the time tag binning histogram.
`timescale 1ns / 1ps

package ttbh_pkg;

  // Store depths; both are powers of two so the phase bin is a low slice
  localparam int PHASE_BINS    = 4096;
  localparam int INTERVAL_BINS = 1024;
  localparam int PHASE_W       = $clog2(PHASE_BINS);
  localparam int INTERVAL_W    = $clog2(INTERVAL_BINS);

  // Field widths
  localparam int TIME_W    = 64;
  localparam int PS_W      = 40;
  localparam int SEC_W     = 24;
  localparam int IDX_W     = 12;
  localparam int CNT_W     = 32;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 64;
  localparam int WIDTH_W   = 40;
  localparam int SHIFT_W   = 40;

  // 10^12 = 244140625 * 2^12: a 24x28 multiply followed by a shift
  localparam int          PS_SEC_ODD_W = 28;
  localparam logic [PS_SEC_ODD_W-1:0] PS_SEC_ODD = 28'd244140625;
  localparam int          PS_SEC_SHIFT = 12;
  localparam int          PROD_W       = SEC_W + PS_SEC_ODD_W;

  // Divider iteration counter
  localparam int DIV_CNT_W = $clog2(TIME_W + 1);

  // Input beat layout (tdata, lowest bit first)
  localparam int IN_PS_LSB   = 0;
  localparam int IN_SEC_LSB  = IN_PS_LSB + PS_W;
  localparam int IN_IDX_LSB  = IN_SEC_LSB + SEC_W;
  localparam int IN_TDATA_W  = 80;

  // Output beat layout (tdata, lowest bit first)
  localparam int OUT_PBIN_LSB    = 0;
  localparam int OUT_IBIN_LSB    = OUT_PBIN_LSB + PHASE_W;
  localparam int OUT_COUNTED_BIT = OUT_IBIN_LSB + INTERVAL_W;
  localparam int OUT_COUNT_LSB   = OUT_COUNTED_BIT + 1;
  localparam int OUT_PAYLOAD_W   = OUT_COUNT_LSB + CNT_W;
  localparam int OUT_TDATA_W     = 56;

  typedef enum logic [OP_W-1:0] {
    OP_TAG         = 2'd0,
    OP_RD_PHASE    = 2'd1,
    OP_RD_INTERVAL = 2'd2,
    OP_CLEAR       = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAU   = 2'd0,
    REG_WIDTH = 2'd1,
    REG_SHIFT = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_DIVP,
    ST_WAITP,
    ST_DIVI,
    ST_WAITI,
    ST_UPD,
    ST_WRITE,
    ST_READ,
    ST_READ_WAIT,
    ST_CLEAR,
    ST_OUT
  } state_t;

  // Saturating increment of a bin count
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (&c) ? c : c + CNT_W'(1);
  endfunction

endpackage

@@ src/ttbh_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle, 64-bit operands.
`timescale 1ns / 1ps

module ttbh_div
  import ttbh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [TIME_W-1:0] dividend,
  input  logic [TIME_W-1:0] divisor,
  output logic              done,
  output logic [TIME_W-1:0] quotient
);

  logic [TIME_W-1:0]    rem;
  logic [TIME_W-1:0]    quo;
  logic [TIME_W-1:0]    dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;

  logic [TIME_W:0]      shifted;
  logic                 ge;
  logic [TIME_W:0]      rem_next;

  // One trial subtract per cycle
  always_comb begin
    shifted  = {rem, quo[TIME_W-1]};
    ge       = shifted >= {1'b0, dvs};
    rem_next = ge ? shifted - {1'b0, dvs} : shifted;
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(TIME_W);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next[TIME_W-1:0];
      quo <= {quo[TIME_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

@@ src/time_tag_binning_histogram.sv @@
// Top level: time tag to phase and interval histograms with a shared divider.
//
//  channel   dir  handshake              payload
//  s_axis    in   s_axis_tvalid/tready   tuser opcode; tdata ps, seconds, bin_index
//  m_axis    out  m_axis_tvalid/tready   tdata phase_bin, interval_bin, counted, count
//  cfg       in   cfg_we                 cfg_index, cfg_data (no read-back)
//
//  A time tag runs multiply, add, two passes of the radix-2 divider (phase,
//  then bin width) and read-modify-write steps before the next accept; the
//  bin width pass is skipped when no interval is formed.
//  A read returns one stored count; a clear sweeps both stores.
//  After reset a clearing pass runs with s_axis_tready low.
//  s_axis_tready is high only in the idle state; the output register lets
//  the next beat in while a result waits; the engine stalls only when a
//  new result is ready and the previous one is still unaccepted.
`timescale 1ns / 1ps

module time_tag_binning_histogram
  import ttbh_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // input beat
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // picoseconds, seconds, bin_index, zero pad
  input  logic [OP_W-1:0]        s_axis_tuser,  // opcode
  // result beat
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // phase_bin, interval_bin, interval_counted,
                                                // count, zero pad
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  state_t state, state_next;

  // Configuration registers
  logic [TIME_W-1:0]  tau_ps;
  logic [WIDTH_W-1:0] interval_bin_width;
  logic [SHIFT_W-1:0] time_shift;

  // Latched input beat
  op_t              op_q;
  logic [PS_W-1:0]  ps_q;
  logic [SEC_W-1:0] sec_q;
  logic [IDX_W-1:0] idx_q;

  // Tag arithmetic
  logic [PROD_W-1:0] prod;
  logic [TIME_W-1:0] total;
  logic [TIME_W-1:0] previous_time;
  logic              have_previous;
  logic [TIME_W-1:0] diff;

  // Result fields
  logic [PHASE_W-1:0]    pbin;
  logic [INTERVAL_W-1:0] ibin;
  logic                  counted;
  logic [CNT_W-1:0]      res_count;

  logic [PHASE_W-1:0] clr_cnt;
  logic               clr_last;

  // Divider hookup
  logic              div_start;
  logic [TIME_W-1:0] div_dividend;
  logic [TIME_W-1:0] div_divisor;
  logic              div_done;
  logic [TIME_W-1:0] div_quo;
  logic [TIME_W-1:0] tau_nz;
  logic [TIME_W-1:0] width_nz;

  // Count stores
  logic [CNT_W-1:0]      phase_mem [PHASE_BINS];
  logic [CNT_W-1:0]      interval_mem [INTERVAL_BINS];
  logic                  p_we;
  logic [PHASE_W-1:0]    p_addr;
  logic [CNT_W-1:0]      p_wdata;
  logic [CNT_W-1:0]      p_rdata;
  logic                  i_we;
  logic [INTERVAL_W-1:0] i_addr;
  logic [CNT_W-1:0]      i_wdata;
  logic [CNT_W-1:0]      i_rdata;

  logic load_out;
  logic tag_has_interval;

  assign tau_nz   = (tau_ps == '0) ? TIME_W'(1) : tau_ps;
  assign width_nz = (interval_bin_width == '0) ? TIME_W'(1)
                                               : TIME_W'(interval_bin_width);
  assign clr_last = (clr_cnt == PHASE_W'(PHASE_BINS - 1));
  assign tag_has_interval = have_previous && (total >= previous_time);
  assign s_axis_tready = (state == ST_IDLE);

  ttbh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tau_ps             <= TIME_W'(1);
      interval_bin_width <= WIDTH_W'(1);
      time_shift         <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TAU:   tau_ps             <= cfg_data;
        REG_WIDTH: interval_bin_width <= cfg_data[WIDTH_W-1:0];
        REG_SHIFT: time_shift         <= cfg_data[SHIFT_W-1:0];
        default:   ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_INIT;
    else     state <= state_next;
  end

  // Sequencer: next state and per-state controls
  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = total;
    div_divisor  = tau_nz;
    p_we         = 1'b0;
    p_addr       = pbin;
    p_wdata      = sat_inc(p_rdata);
    i_we         = 1'b0;
    i_addr       = ibin;
    i_wdata      = sat_inc(i_rdata);
    load_out     = 1'b0;
    case (state)
      ST_INIT, ST_CLEAR: begin
        p_we    = 1'b1;
        p_addr  = clr_cnt;
        p_wdata = '0;
        i_we    = (int'(clr_cnt) < INTERVAL_BINS);
        i_addr  = clr_cnt[INTERVAL_W-1:0];
        i_wdata = '0;
        if (clr_last) state_next = (state == ST_INIT) ? ST_IDLE : ST_OUT;
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          case (op_t'(s_axis_tuser))
            OP_TAG:                      state_next = ST_MUL;
            OP_RD_PHASE, OP_RD_INTERVAL: state_next = ST_READ;
            OP_CLEAR:                    state_next = ST_CLEAR;
            default:                     state_next = ST_IDLE;
          endcase
        end
      end
      ST_MUL: state_next = ST_SUM;
      ST_SUM: state_next = ST_DIVP;
      ST_DIVP: begin
        div_start  = 1'b1;
        state_next = ST_WAITP;
      end
      ST_WAITP: begin
        if (div_done) state_next = tag_has_interval ? ST_DIVI : ST_UPD;
      end
      ST_DIVI: begin
        div_start    = 1'b1;
        div_dividend = diff;
        div_divisor  = width_nz;
        state_next   = ST_WAITI;
      end
      ST_WAITI: begin
        if (div_done) state_next = ST_UPD;
      end
      ST_UPD:   state_next = ST_WRITE;
      ST_WRITE: begin
        p_we       = 1'b1;
        i_we       = counted;
        state_next = ST_OUT;
      end
      ST_READ: begin
        p_addr     = idx_q[PHASE_W-1:0];
        i_addr     = idx_q[INTERVAL_W-1:0];
        state_next = ST_READ_WAIT;
      end
      ST_READ_WAIT: state_next = ST_OUT;
      ST_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Clear sweep counter and tag history
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt       <= '0;
      have_previous <= 1'b0;
      previous_time <= '0;
    end else begin
      if (state == ST_INIT || state == ST_CLEAR) clr_cnt <= clr_cnt + PHASE_W'(1);
      if (state == ST_WAITP && div_done) begin
        previous_time <= total;
        have_previous <= 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          op_q      <= op_t'(s_axis_tuser);
          ps_q      <= s_axis_tdata[IN_PS_LSB +: PS_W];
          sec_q     <= s_axis_tdata[IN_SEC_LSB +: SEC_W];
          idx_q     <= s_axis_tdata[IN_IDX_LSB +: IDX_W];
          pbin      <= '0;
          ibin      <= '0;
          counted   <= 1'b0;
          res_count <= '0;
        end
      end
      ST_MUL: prod <= PROD_W'(sec_q) * PROD_W'(PS_SEC_ODD);
      ST_SUM: total <= {prod, PS_SEC_SHIFT'(0)} + TIME_W'(ps_q) + TIME_W'(time_shift);
      ST_WAITP: begin
        if (div_done) begin
          pbin <= div_quo[PHASE_W-1:0];
          diff <= total - previous_time;
        end
      end
      ST_WAITI: begin
        if (div_done && (div_quo < TIME_W'(INTERVAL_BINS))) begin
          ibin    <= div_quo[INTERVAL_W-1:0];
          counted <= 1'b1;
        end
      end
      ST_READ_WAIT: begin
        if (op_q == OP_RD_PHASE)
          res_count <= (int'(idx_q) < PHASE_BINS) ? p_rdata : '0;
        else
          res_count <= (int'(idx_q) < INTERVAL_BINS) ? i_rdata : '0;
      end
      default: ;
    endcase
  end

  // Phase count store
  always_ff @(posedge clk) begin
    if (p_we) phase_mem[p_addr] <= p_wdata;
    p_rdata <= phase_mem[p_addr];
  end

  // Interval count store
  always_ff @(posedge clk) begin
    if (i_we) interval_mem[i_addr] <= i_wdata;
    i_rdata <= interval_mem[i_addr];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= {(OUT_TDATA_W - OUT_PAYLOAD_W)'(0), res_count, counted, ibin, pbin};
    end
  end

endmodule

@@ src/ttbh_check.sv @@
// Port-level checks for the time tag binning histogram, bound to the top level.
`timescale 1ns / 1ps

module ttbh_check
  import ttbh_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // No result is left pending across reset
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // One item at a time: ready drops after each accepted beat
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while busy");

  // A result never appears in the cycle after an input beat is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

  // An uncounted interval reports bin zero
  a_uncounted_bin_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[OUT_COUNTED_BIT] ||
                       (m_axis_tdata[OUT_IBIN_LSB +: INTERVAL_W] == '0)))
    else $error("interval bin set without count");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind time_tag_binning_histogram ttbh_check u_ttbh_check (.*);
